// ===== hdl/pld_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pld_pkg: shared types and constants of the line follower drive
// Sizes, register codes, state codes and structs used by every file.
// ----------------------------------------------------------------------------
package pld_pkg;

    localparam int SENSOR_COUNT = 5;
    localparam int FRAC_BITS    = 8;

    localparam int SAMPLE_W = 10;
    localparam int DUTY_W   = 8;
    localparam int MODE_W   = 2;
    localparam int GAIN_W   = 16;
    localparam int PDATA_W  = 32;
    localparam int PADDR_W  = 5;
    localparam int REGIDX_W = PADDR_W - 2;

    function automatic int max_wsum();
        int s;
        s = 0;
        for (int i = 0; i < SENSOR_COUNT; i++) begin
            if (2 * i - (SENSOR_COUNT - 1) > 0) begin
                s += 2 * i - (SENSOR_COUNT - 1);
            end
        end
        return s;
    endfunction

    localparam int MAG_W     = $clog2(max_wsum() + 1);
    localparam int WSUM_W    = MAG_W + 1;
    localparam int HIT_W     = $clog2(SENSOR_COUNT + 1);
    localparam int WEIGHT_W  = $clog2(SENSOR_COUNT) + 1;
    localparam int ERR_W     = $clog2(SENSOR_COUNT) + FRAC_BITS + 1;
    localparam int DIV_STEPS = (MAG_W + FRAC_BITS + 1) / 2;
    localparam int DIVD_W    = 2 * DIV_STEPS;
    localparam int REM_W     = HIT_W + 1;
    localparam int DSTEP_W   = $clog2(DIV_STEPS + 1);

    localparam int INTEG_LIMIT = 100 << FRAC_BITS;
    localparam int SUM_W       = $clog2(INTEG_LIMIT) + 2;
    localparam int DIFF_W      = ERR_W + 1;
    localparam int OPND_W      = (SUM_W > DIFF_W) ? SUM_W : DIFF_W;
    localparam int PROD_W      = GAIN_W + 1 + OPND_W;
    localparam int ACC_W       = PROD_W + 2;
    localparam int DRV_W       = ACC_W + 1;
    localparam int CORR_SHIFT  = FRAC_BITS + 8;
    localparam int DUTY_MAX    = (1 << DUTY_W) - 1;

    localparam logic signed [SUM_W-1:0] SUM_LIM_P = SUM_W'(INTEG_LIMIT);
    localparam logic signed [SUM_W-1:0] SUM_LIM_N = -SUM_W'(INTEG_LIMIT);
    localparam logic signed [ACC_W-1:0] ROUND_ADD = ACC_W'((1 << CORR_SHIFT) - 1);

    localparam logic [DUTY_W-1:0] CRUISE_RST = DUTY_W'(170);
    localparam logic [SAMPLE_W-1:0] DARK_RST = SAMPLE_W'(500);
    localparam logic [GAIN_W-1:0] PGAIN_RST  = GAIN_W'(6400);
    localparam logic [GAIN_W-1:0] IGAIN_RST  = GAIN_W'(0);
    localparam logic [GAIN_W-1:0] DGAIN_RST  = GAIN_W'(3840);

    typedef enum logic [REGIDX_W-1:0] {
        REG_CRUISE,
        REG_DARK,
        REG_PGAIN,
        REG_IGAIN,
        REG_DGAIN
    } t_reg_idx;

    typedef enum logic [MODE_W-1:0] {
        MODE_PID,
        MODE_STRAIGHT,
        MODE_SEARCH_L,
        MODE_SEARCH_R
    } t_mode;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CLASS,
        ST_DIV,
        ST_INTEG,
        ST_MUL,
        ST_ACC,
        ST_CORR,
        ST_DONE
    } t_state;

    typedef enum logic [1:0] {
        TERM_P,
        TERM_I,
        TERM_D
    } t_term;

    typedef struct packed {
        logic [DUTY_W-1:0]   cruise;
        logic [SAMPLE_W-1:0] dark;
        logic [GAIN_W-1:0]   kp;
        logic [GAIN_W-1:0]   ki;
        logic [GAIN_W-1:0]   kd;
    } t_cfg;

    typedef struct packed {
        logic                       hit;
        logic signed [WEIGHT_W-1:0] weight;
    } t_lane_res;

    typedef struct packed {
        logic signed [WSUM_W-1:0] wsum;
        logic [HIT_W-1:0]         hits;
    } t_merge;

endpackage

// ===== hdl/pld_intf.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pld_intf: item channels of the line follower drive
// Sensor item channel and drive result channel, valid/ready handshake.
// ----------------------------------------------------------------------------
interface pld_in_if import pld_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [SAMPLE_W-1:0] sensor_far_left;
    logic [SAMPLE_W-1:0] sensor_left;
    logic [SAMPLE_W-1:0] sensor_center;
    logic [SAMPLE_W-1:0] sensor_right;
    logic [SAMPLE_W-1:0] sensor_far_right;

    modport source (
        output valid, sensor_far_left, sensor_left, sensor_center, sensor_right,
        output sensor_far_right,
        input  ready
    );
    modport sink (
        input  valid, sensor_far_left, sensor_left, sensor_center, sensor_right,
        input  sensor_far_right,
        output ready
    );
endinterface

interface pld_out_if import pld_pkg::*; ();
    logic                    valid;
    logic                    ready;
    logic [DUTY_W-1:0]       left_drive;
    logic [DUTY_W-1:0]       right_drive;
    logic [MODE_W-1:0]       drive_mode;
    logic signed [ERR_W-1:0] line_offset;

    modport source (
        output valid, left_drive, right_drive, drive_mode, line_offset,
        input  ready
    );
    modport sink (
        input  valid, left_drive, right_drive, drive_mode, line_offset,
        output ready
    );
endinterface

// ===== hdl/pld_lane.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pld_lane: one sensor lane
// Compares a sample with the dark level and yields its weight on a hit.
// ----------------------------------------------------------------------------
module pld_lane import pld_pkg::*; (
    input  logic [SAMPLE_W-1:0]        i_sample,
    input  logic [SAMPLE_W-1:0]        i_dark,
    input  logic signed [WEIGHT_W-1:0] i_weight,
    output t_lane_res                  o_res
);

    logic w_hit;

    assign w_hit        = (i_sample < i_dark);
    assign o_res.hit    = w_hit;
    assign o_res.weight = w_hit ? i_weight : '0;

endmodule

// ===== hdl/pld_merge.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pld_merge: lane merge stage
// Adds the lane weights and counts hits, registered when an item is taken.
// ----------------------------------------------------------------------------
module pld_merge import pld_pkg::*; (
    input  logic      i_clk,
    input  logic      i_load,
    input  t_lane_res i_lanes [SENSOR_COUNT],
    output t_merge    o_merge
);

    logic signed [WSUM_W-1:0] w_wsum;
    logic [HIT_W-1:0]         w_hits;
    t_merge                   r_merge;

    always_comb begin
        w_wsum = '0;
        w_hits = '0;
        for (int i = 0; i < SENSOR_COUNT; i++) begin
            if (i_lanes[i].hit) begin
                w_wsum = w_wsum + WSUM_W'(i_lanes[i].weight);
                w_hits = w_hits + HIT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_merge.wsum <= w_wsum;
            r_merge.hits <= w_hits;
        end
    end

    assign o_merge = r_merge;

endmodule

// ===== hdl/pld_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pld_core: control step sequencer
// Mean divider, shared PID multiplier, integral state and result register.
// ----------------------------------------------------------------------------
module pld_core import pld_pkg::*; (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_start,
    input  t_merge                  i_merge,
    input  t_cfg                    i_cfg,
    input  logic                    i_out_ready,
    output logic                    o_ready,
    output logic                    o_out_valid,
    output logic [DUTY_W-1:0]       o_left_drive,
    output logic [DUTY_W-1:0]       o_right_drive,
    output logic [MODE_W-1:0]       o_drive_mode,
    output logic signed [ERR_W-1:0] o_line_offset
);

    t_state r_state, n_state;

    logic [REM_W-1:0]         r_rem, w_rem;
    logic [DIVD_W-1:0]        r_quo, w_quo;
    logic [REM_W-1:0]         w_trial;
    logic                     r_neg;
    logic [DSTEP_W-1:0]       r_step;
    logic [MAG_W-1:0]         w_mag;

    logic signed [ERR_W-1:0]  w_qmag, w_err, r_err, r_last;
    logic signed [SUM_W-1:0]  w_sum_raw, w_sum_clamp, r_sum;
    logic signed [DIFF_W-1:0] r_diff;

    t_term                    r_idx;
    logic signed [OPND_W-1:0] w_opnd;
    logic [GAIN_W-1:0]        w_gain;
    logic signed [PROD_W-1:0] r_prod;
    logic signed [ACC_W-1:0]  r_acc, w_acc_adj, w_corr;
    logic signed [DRV_W-1:0]  w_base, w_lsum, w_rsum;

    logic [DUTY_W-1:0]        r_res_left, r_res_right;
    t_mode                    r_res_mode;
    logic signed [ERR_W-1:0]  r_res_off;

    logic                     r_o_valid;
    logic [DUTY_W-1:0]        r_o_left, r_o_right;
    t_mode                    r_o_mode;
    logic signed [ERR_W-1:0]  r_o_off;

    logic                     w_load;
    logic                     w_special;

    function automatic logic [DUTY_W-1:0] clamp_duty(input logic signed [DRV_W-1:0] v);
        logic [DUTY_W-1:0] d;
        if (v < 0) begin
            d = '0;
        end else if (v > DRV_W'(DUTY_MAX)) begin
            d = DUTY_W'(DUTY_MAX);
        end else begin
            d = v[DUTY_W-1:0];
        end
        return d;
    endfunction

    assign w_special = (i_merge.hits == HIT_W'(SENSOR_COUNT)) || (i_merge.hits == '0);
    assign w_mag     = i_merge.wsum[WSUM_W-1] ? MAG_W'(-i_merge.wsum) : MAG_W'(i_merge.wsum);

    // two restoring steps per cycle
    always_comb begin
        w_rem   = r_rem;
        w_quo   = r_quo;
        w_trial = '0;
        for (int k = 0; k < 2; k++) begin
            w_trial = {w_rem[REM_W-2:0], w_quo[DIVD_W-1]};
            if (w_trial >= REM_W'(i_merge.hits)) begin
                w_rem = w_trial - REM_W'(i_merge.hits);
                w_quo = {w_quo[DIVD_W-2:0], 1'b1};
            end else begin
                w_rem = w_trial;
                w_quo = {w_quo[DIVD_W-2:0], 1'b0};
            end
        end
    end

    always_comb begin
        w_qmag    = ERR_W'(r_quo);
        w_err     = r_neg ? -w_qmag : w_qmag;
        w_sum_raw = r_sum + SUM_W'(w_err);
        if (w_sum_raw > SUM_LIM_P) begin
            w_sum_clamp = SUM_LIM_P;
        end else if (w_sum_raw < SUM_LIM_N) begin
            w_sum_clamp = SUM_LIM_N;
        end else begin
            w_sum_clamp = w_sum_raw;
        end
    end

    always_comb begin
        case (r_idx)
            TERM_P: begin
                w_opnd = OPND_W'(r_err);
                w_gain = i_cfg.kp;
            end
            TERM_I: begin
                w_opnd = OPND_W'(r_sum);
                w_gain = i_cfg.ki;
            end
            TERM_D: begin
                w_opnd = OPND_W'(r_diff);
                w_gain = i_cfg.kd;
            end
            default: begin
                w_opnd = '0;
                w_gain = '0;
            end
        endcase
    end

    always_comb begin
        w_acc_adj = r_acc + (r_acc[ACC_W-1] ? ROUND_ADD : ACC_W'(0));
        w_corr    = w_acc_adj >>> CORR_SHIFT;
        w_base    = DRV_W'({1'b0, i_cfg.cruise});
        w_lsum    = w_base + DRV_W'(w_corr);
        w_rsum    = w_base - DRV_W'(w_corr);
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE:  if (i_start) n_state = ST_CLASS;
            ST_CLASS: n_state = w_special ? ST_DONE : ST_DIV;
            ST_DIV:   if (r_step == DSTEP_W'(DIV_STEPS - 1)) n_state = ST_INTEG;
            ST_INTEG: n_state = ST_MUL;
            ST_MUL:   if (r_idx == TERM_D) n_state = ST_ACC;
            ST_ACC:   n_state = ST_CORR;
            ST_CORR:  n_state = ST_DONE;
            ST_DONE:  if (w_load) n_state = ST_IDLE;
            default:  n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_ready = (r_state == ST_IDLE);
        w_load  = (r_state == ST_DONE) && (!r_o_valid || i_out_ready);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_o_valid <= 1'b0;
            r_sum     <= '0;
            r_last    <= '0;
        end else begin
            r_state <= n_state;
            if (w_load) begin
                r_o_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_o_valid <= 1'b0;
            end
            if (r_state == ST_INTEG) begin
                r_sum <= w_sum_clamp;
            end
            if (r_state == ST_CORR) begin
                r_last <= r_err;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            ST_CLASS: begin
                r_rem  <= '0;
                r_quo  <= DIVD_W'(w_mag) << FRAC_BITS;
                r_neg  <= i_merge.wsum[WSUM_W-1];
                r_step <= '0;
                r_res_off <= '0;
                if (i_merge.hits == HIT_W'(SENSOR_COUNT)) begin
                    r_res_left  <= i_cfg.cruise;
                    r_res_right <= i_cfg.cruise;
                    r_res_mode  <= MODE_STRAIGHT;
                end else if (r_last < 0) begin
                    r_res_left  <= '0;
                    r_res_right <= i_cfg.cruise;
                    r_res_mode  <= MODE_SEARCH_L;
                end else begin
                    r_res_left  <= i_cfg.cruise;
                    r_res_right <= '0;
                    r_res_mode  <= MODE_SEARCH_R;
                end
            end
            ST_DIV: begin
                r_rem  <= w_rem;
                r_quo  <= w_quo;
                r_step <= r_step + DSTEP_W'(1);
            end
            ST_INTEG: begin
                r_err  <= w_err;
                r_diff <= DIFF_W'(w_err) - DIFF_W'(r_last);
                r_idx  <= TERM_P;
            end
            ST_MUL: begin
                r_prod <= $signed({1'b0, w_gain}) * w_opnd;
                r_idx  <= t_term'(r_idx + 2'd1);
                if (r_idx == TERM_P) begin
                    r_acc <= '0;
                end else begin
                    r_acc <= r_acc + ACC_W'(r_prod);
                end
            end
            ST_ACC: begin
                r_acc <= r_acc + ACC_W'(r_prod);
            end
            ST_CORR: begin
                r_res_left  <= clamp_duty(w_lsum);
                r_res_right <= clamp_duty(w_rsum);
                r_res_mode  <= MODE_PID;
                r_res_off   <= r_err;
            end
            default: begin
            end
        endcase
        if (w_load) begin
            r_o_left  <= r_res_left;
            r_o_right <= r_res_right;
            r_o_mode  <= r_res_mode;
            r_o_off   <= r_res_off;
        end
    end

    assign o_out_valid   = r_o_valid;
    assign o_left_drive  = r_o_left;
    assign o_right_drive = r_o_right;
    assign o_drive_mode  = r_o_mode;
    assign o_line_offset = r_o_off;

endmodule

// ===== hdl/pid_line_follower_drive.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pid_line_follower_drive: PID wheel drive from a reflectance sensor array
// Sensor lanes, merge stage, control step sequencer and APB registers.
// ----------------------------------------------------------------------------
// One sensor item is taken at a time. An item in which all or none of the
// sensors see the line goes from the classify state straight to the done
// state; an item that runs the PID step passes the mean divider, which
// resolves two quotient bits a cycle, and the single multiplier that forms
// the three gain products in turn. A finished result waits in the output
// register while the next item is taken. The user must write the registers
// through the APB port only while idle; the block does not enforce it.
module pid_line_follower_drive import pld_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    pld_in_if.sink             i_in,
    pld_out_if.source          o_out,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready
);

    t_cfg                r_cfg;
    t_reg_idx            w_idx;
    logic                w_wr;
    logic                w_start;
    logic                w_ready;
    logic [SAMPLE_W-1:0] w_samples [SENSOR_COUNT];
    t_lane_res           w_lanes [SENSOR_COUNT];
    t_merge              w_merge;

    assign pready = 1'b1;
    assign w_idx  = t_reg_idx'(paddr[PADDR_W-1:2]);
    assign w_wr   = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.cruise <= CRUISE_RST;
            r_cfg.dark   <= DARK_RST;
            r_cfg.kp     <= PGAIN_RST;
            r_cfg.ki     <= IGAIN_RST;
            r_cfg.kd     <= DGAIN_RST;
        end else if (w_wr) begin
            case (w_idx)
                REG_CRUISE: r_cfg.cruise <= pwdata[DUTY_W-1:0];
                REG_DARK:   r_cfg.dark   <= pwdata[SAMPLE_W-1:0];
                REG_PGAIN:  r_cfg.kp     <= pwdata[GAIN_W-1:0];
                REG_IGAIN:  r_cfg.ki     <= pwdata[GAIN_W-1:0];
                REG_DGAIN:  r_cfg.kd     <= pwdata[GAIN_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (w_idx)
            REG_CRUISE: prdata = PDATA_W'(r_cfg.cruise);
            REG_DARK:   prdata = PDATA_W'(r_cfg.dark);
            REG_PGAIN:  prdata = PDATA_W'(r_cfg.kp);
            REG_IGAIN:  prdata = PDATA_W'(r_cfg.ki);
            REG_DGAIN:  prdata = PDATA_W'(r_cfg.kd);
            default:    prdata = '0;
        endcase
    end

    assign w_samples[0] = i_in.sensor_far_left;
    assign w_samples[1] = i_in.sensor_left;
    assign w_samples[2] = i_in.sensor_center;
    assign w_samples[3] = i_in.sensor_right;
    assign w_samples[4] = i_in.sensor_far_right;

    assign i_in.ready = w_ready;
    assign w_start    = i_in.valid && w_ready;

    for (genvar g = 0; g < SENSOR_COUNT; g++) begin : g_lane
        localparam logic signed [WEIGHT_W-1:0] LANE_WEIGHT =
            WEIGHT_W'(2 * g - (SENSOR_COUNT - 1));
        pld_lane u_lane (
            .i_sample (w_samples[g]),
            .i_dark   (r_cfg.dark),
            .i_weight (LANE_WEIGHT),
            .o_res    (w_lanes[g])
        );
    end

    pld_merge u_merge (
        .i_clk   (i_clk),
        .i_load  (w_start),
        .i_lanes (w_lanes),
        .o_merge (w_merge)
    );

    pld_core u_core (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_start       (w_start),
        .i_merge       (w_merge),
        .i_cfg         (r_cfg),
        .i_out_ready   (o_out.ready),
        .o_ready       (w_ready),
        .o_out_valid   (o_out.valid),
        .o_left_drive  (o_out.left_drive),
        .o_right_drive (o_out.right_drive),
        .o_drive_mode  (o_out.drive_mode),
        .o_line_offset (o_out.line_offset)
    );

endmodule

// ===== hdl/pld_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pld_checker: port checks of the line follower drive
// Result channel behaviour and drive mode consistency.
// ----------------------------------------------------------------------------
module pld_checker import pld_pkg::*; (
    input logic                    i_clk,
    input logic                    i_rst_n,
    input logic                    i_valid,
    input logic                    i_ready,
    input logic [DUTY_W-1:0]       i_left,
    input logic [DUTY_W-1:0]       i_right,
    input logic [MODE_W-1:0]       i_mode,
    input logic signed [ERR_W-1:0] i_offset
);

    a_reset_clears: assert property (@(posedge i_clk) !i_rst_n |=> !i_valid)
        else $error("result valid after reset");

    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !i_ready |=> i_valid && $stable({i_left, i_right, i_mode, i_offset}))
        else $error("stalled item changed");

    a_offset_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && (t_mode'(i_mode) != MODE_PID) |-> i_offset == '0)
        else $error("offset set outside pid mode");

    a_straight_even: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && (t_mode'(i_mode) == MODE_STRAIGHT) |-> i_left == i_right)
        else $error("straight mode with unequal drives");

    a_search_side: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid |-> (t_mode'(i_mode) != MODE_SEARCH_L || i_left == '0)
                 && (t_mode'(i_mode) != MODE_SEARCH_R || i_right == '0))
        else $error("search mode drives wrong wheel");

endmodule

bind pid_line_follower_drive pld_checker u_pld_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .i_valid  (o_out.valid),
    .i_ready  (o_out.ready),
    .i_left   (o_out.left_drive),
    .i_right  (o_out.right_drive),
    .i_mode   (o_out.drive_mode),
    .i_offset (o_out.line_offset)
);
